FILE: hdl/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
package bdlp_pkg;

    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Register map
    localparam t_cfg_idx CFG_PRESSED_LEVEL   = 3'd0;
    localparam t_cfg_idx CFG_RELEASE_ENABLE  = 3'd1;
    localparam t_cfg_idx CFG_LONG_PRESS      = 3'd2;
    localparam t_cfg_idx CFG_SETTLE_ACTIVE   = 3'd3;
    localparam t_cfg_idx CFG_SETTLE_INACTIVE = 3'd4;

    // Reset values of the registers
    localparam logic RST_PRESSED_LEVEL       = 1'b0;
    localparam logic RST_RELEASE_ENABLE      = 1'b1;
    localparam t_cnt RST_LONG_PRESS          = 8'd0;
    localparam t_cnt RST_SETTLE_ACTIVE       = 8'd3;
    localparam t_cnt RST_SETTLE_INACTIVE     = 8'd3;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_RELEASED = 2'd2,
        EV_LONG     = 2'd3
    } t_event;

    // Outcome of the pin check for one tick
    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_EDGE,
        CHK_ACTIVE,
        CHK_INACTIVE,
        CHK_LONG
    } t_chk;

endpackage

FILE: hdl/bdlp_req_if.sv
// Request channel: one sampled pin level per tick.
interface bdlp_req_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

FILE: hdl/bdlp_res_if.sv
// Result channel: one event code and press duration per tick.
interface bdlp_res_if import bdlp_pkg::*; ;
    logic   valid;
    logic   ready;
    t_event event_code;
    t_cnt   press_duration;

    modport source (output valid, output event_code, output press_duration, input ready);
    modport sink   (input valid, input event_code, input press_duration, output ready);
endinterface

FILE: hdl/button_debounce_long_press_unit.sv
// Top level: button debouncer with press, release and repeating long-press events.
//
//   channel   dir   payload                               handshake
//   i_req     in    pin_level (1)                         valid / ready
//   o_res     out   event_code (2), press_duration (8)    valid / ready
//   i_cfg_*   in    i_cfg_index (3), i_cfg_data (8)       i_cfg_we, no stall
//
// One request per cycle: the debounce state is updated in the cycle the request
// is taken, and its result lands in the output register the next cycle.
// The output register is the only stage.
// While a result waits on o_res.ready, a new request is still taken if that
// same edge drains the output register; otherwise i_req.ready drops.
// Reset (synchronous, active low) loads register defaults and the released state.
// A write to pressed_level puts the debounce state back to reset under the new polarity.
module button_debounce_long_press_unit
    import bdlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  t_cfg_data   i_cfg_data,
    bdlp_req_if.sink    i_req,
    bdlp_res_if.source  o_res
);

    // Configuration registers
    logic r_pressed_level;
    logic r_release_enable;
    t_cnt r_long_ticks;
    t_cnt r_settle_active;
    t_cnt r_settle_inactive;

    // Debounce state
    logic r_button_down;
    logic r_edge_level;
    logic r_settled;
    logic r_last_level;
    t_cnt r_active_ticks;
    t_cnt r_inactive_ticks;
    t_cnt r_held_ticks;

    logic n_button_down;
    logic n_edge_level;
    logic n_settled;
    t_cnt n_active_ticks;
    t_cnt n_inactive_ticks;
    t_cnt n_held_ticks;

    // Output register
    logic   r_out_valid;
    t_event r_event;
    t_cnt   r_duration;

    t_event n_event;
    t_cnt   n_duration;
    t_chk   chk;
    t_cnt   active_inc;
    t_cnt   inactive_inc;
    logic   lvl;
    logic   req_take;
    logic   polarity_wr;

    // Take a request whenever the output register is empty or drains this edge
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_take    = i_req.valid && i_req.ready;
    assign polarity_wr = i_cfg_we && (i_cfg_index == CFG_PRESSED_LEVEL);

    assign lvl          = i_req.pin_level;
    assign active_inc   = r_active_ticks + t_cnt'(1);
    assign inactive_inc = r_inactive_ticks + t_cnt'(1);

    // Pin check: edge detect, settle counting and long-press repeat
    always_comb begin
        chk              = CHK_NONE;
        n_settled        = r_settled;
        n_active_ticks   = r_active_ticks;
        n_inactive_ticks = r_inactive_ticks;
        if (r_settled) begin
            if (lvl == r_edge_level && r_last_level != r_edge_level) begin
                chk              = CHK_EDGE;
                n_active_ticks   = '0;
                n_inactive_ticks = '0;
                n_settled        = 1'b0;
            end else if (lvl != r_edge_level && r_edge_level != r_pressed_level) begin
                // Held and settled: count toward the next long-press event
                n_inactive_ticks = '0;
                n_active_ticks   = active_inc;
                if (r_long_ticks != '0 && active_inc >= r_long_ticks) begin
                    n_active_ticks = '0;
                    chk            = CHK_LONG;
                end
            end
        end else if (lvl == r_edge_level) begin
            n_inactive_ticks = '0;
            n_active_ticks   = active_inc;
            if (active_inc >= r_settle_active) begin
                n_settled = 1'b1;
                chk       = CHK_ACTIVE;
            end
        end else begin
            n_active_ticks   = '0;
            n_inactive_ticks = inactive_inc;
            if (inactive_inc >= r_settle_inactive) begin
                n_settled = 1'b1;
                chk       = CHK_INACTIVE;
            end
        end
    end

    // Button state and event selection
    always_comb begin
        n_event       = EV_NONE;
        n_duration    = '0;
        n_button_down = r_button_down;
        n_edge_level  = r_edge_level;
        n_held_ticks  = r_held_ticks;
        if (!r_button_down) begin
            if (chk == CHK_EDGE) begin
                n_event       = EV_PRESSED;
                n_held_ticks  = '0;
                n_button_down = 1'b1;
            end
        end else begin
            unique case (chk)
                CHK_NONE: begin
                    n_held_ticks = r_held_ticks + t_cnt'(1);
                end
                CHK_ACTIVE: begin
                    // Settled on the press level: now wait for the release edge
                    n_edge_level = !r_edge_level;
                end
                CHK_INACTIVE: begin
                    // Bounce never settled: drop the press silently
                    n_edge_level  = r_pressed_level;
                    n_button_down = 1'b0;
                end
                CHK_EDGE: begin
                    if (r_release_enable) begin
                        n_event    = EV_RELEASED;
                        n_duration = r_held_ticks;
                    end
                    n_edge_level  = r_pressed_level;
                    n_button_down = 1'b0;
                end
                CHK_LONG: begin
                    n_event = EV_LONG;
                end
                default: begin
                    n_event = EV_NONE;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level   <= RST_PRESSED_LEVEL;
            r_release_enable  <= RST_RELEASE_ENABLE;
            r_long_ticks      <= RST_LONG_PRESS;
            r_settle_active   <= RST_SETTLE_ACTIVE;
            r_settle_inactive <= RST_SETTLE_INACTIVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESSED_LEVEL:   r_pressed_level   <= i_cfg_data[0];
                CFG_RELEASE_ENABLE:  r_release_enable  <= i_cfg_data[0];
                CFG_LONG_PRESS:      r_long_ticks      <= i_cfg_data;
                CFG_SETTLE_ACTIVE:   r_settle_active   <= i_cfg_data;
                CFG_SETTLE_INACTIVE: r_settle_inactive <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Debounce state: reset and polarity writes clear it, a taken request advances it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_down    <= 1'b0;
            r_edge_level     <= RST_PRESSED_LEVEL;
            r_settled        <= 1'b1;
            r_last_level     <= !RST_PRESSED_LEVEL;
            r_active_ticks   <= '0;
            r_inactive_ticks <= '0;
            r_held_ticks     <= '0;
        end else if (polarity_wr) begin
            r_button_down    <= 1'b0;
            r_edge_level     <= i_cfg_data[0];
            r_settled        <= 1'b1;
            r_last_level     <= !i_cfg_data[0];
            r_active_ticks   <= '0;
            r_inactive_ticks <= '0;
            r_held_ticks     <= '0;
        end else if (req_take) begin
            r_button_down    <= n_button_down;
            r_edge_level     <= n_edge_level;
            r_settled        <= n_settled;
            r_last_level     <= lvl;
            r_active_ticks   <= n_active_ticks;
            r_inactive_ticks <= n_inactive_ticks;
            r_held_ticks     <= n_held_ticks;
        end
    end

    // Output register: load on a taken request, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_event    <= n_event;
            r_duration <= n_duration;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.event_code     = r_event;
    assign o_res.press_duration = r_duration;

    // A release is reported only from the pressed state with reporting enabled
    a_release_from_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && n_event == EV_RELEASED) |-> (r_button_down && r_release_enable))
        else $error("release event while button not down or reporting disabled");

    // A press event leaves the button down
    a_press_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && !polarity_wr && n_event == EV_PRESSED) |=> r_button_down)
        else $error("press event did not set button down");

    // Long press only while held, settled and enabled
    a_long_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && n_event == EV_LONG) |->
            (r_button_down && r_settled && r_long_ticks != '0))
        else $error("long press outside a settled hold");

    // A polarity write restores the released state under the new level
    a_polarity_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        polarity_wr |=> (!r_button_down && r_settled && r_edge_level == r_pressed_level
                         && r_last_level != r_pressed_level && r_held_ticks == '0))
        else $error("polarity write did not clear debounce state");

endmodule

FILE: bench/tb_button_debounce_long_press_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the button debouncer: directed and random pin streams against a cycle-free predictor.
module tb_button_debounce_long_press_unit;
    import bdlp_pkg::*;

    localparam time         CLK_PERIOD      = 12ns;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 240;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RANDOM_PHASES   = 4;
    localparam int unsigned PHASE_ITEMS     = 20;
    // Not in the register map: writes here must leave every register alone.
    localparam t_cfg_idx    CFG_UNMAPPED    = 3'd7;
    // Hand-written opening stream under reset settings, first tick in the MSB:
    // idle, press, settle, hold, release, release settle, press, bounce back
    // until the press is dropped, press again, settle, release.
    localparam logic [21:0] DIRECTED_PINS   = 22'b1000000111101110000111;

    // One expected output of the block for one tick.
    typedef struct packed {
        t_event code;
        t_cnt   dur;
    } t_tick_result;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    bdlp_req_if req_ch ();
    bdlp_res_if res_ch ();

    button_debounce_long_press_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    // Pin levels waiting to be offered, and results owed by the block.
    logic         pin_queue [$];
    t_tick_result tick_results [$];

    // Predictor copy of the registers.
    logic cf_pressed;
    logic cf_release;
    t_cnt cf_long;
    t_cnt cf_act;
    t_cnt cf_inact;

    // Predictor copy of the debounce state.
    logic st_down;
    logic st_edge;
    logic st_settled;
    logic st_last;
    t_cnt st_act;
    t_cnt st_inact;
    t_cnt st_held;

    int unsigned mismatches;
    int unsigned send_gap;
    int unsigned sink_stall;
    int unsigned hold_left;
    logic        steady;       // no idling on either side while set
    logic        hold_off_req; // ask the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Put the debounce state back to released under the current polarity.
    function automatic void clear_debouncer();
        st_down    = 1'b0;
        st_edge    = cf_pressed;
        st_settled = 1'b1;
        st_last    = ~cf_pressed;
        st_act     = '0;
        st_inact   = '0;
        st_held    = '0;
    endfunction

    // Advance the debouncer by one pin sample and return the event it raises.
    function automatic t_tick_result advance_debouncer(input logic lvl);
        t_chk         chk;
        t_tick_result r;
        chk    = CHK_NONE;
        r.code = EV_NONE;
        r.dur  = '0;
        // Pin check: edge detection, settling and long-press counting.
        if (st_settled) begin
            if (lvl == st_edge && st_last != st_edge) begin
                chk        = CHK_EDGE;
                st_act     = '0;
                st_inact   = '0;
                st_settled = 1'b0;
            end else if (lvl != st_edge && st_edge != cf_pressed) begin
                // Settled in the pressed state: count toward the next long press.
                st_inact = '0;
                st_act   = st_act + 8'd1;
                if (cf_long != 0 && st_act >= cf_long) begin
                    st_act = '0;
                    chk    = CHK_LONG;
                end
            end
        end else if (lvl == st_edge) begin
            st_inact = '0;
            st_act   = st_act + 8'd1;
            if (st_act >= cf_act) begin
                st_settled = 1'b1;
                chk        = CHK_ACTIVE;
            end
        end else begin
            st_act   = '0;
            st_inact = st_inact + 8'd1;
            if (st_inact >= cf_inact) begin
                st_settled = 1'b1;
                chk        = CHK_INACTIVE;
            end
        end
        st_last = lvl;

        // Button state machine on top of the pin check.
        if (!st_down) begin
            if (chk == CHK_EDGE) begin
                r.code  = EV_PRESSED;
                st_held = '0;
                st_down = 1'b1;
            end
        end else begin
            case (chk)
                CHK_NONE: begin
                    st_held = st_held + 8'd1;
                end
                CHK_ACTIVE: begin
                    st_edge = ~st_edge;
                end
                CHK_INACTIVE: begin
                    // Press never settled: drop it without an event.
                    st_edge = cf_pressed;
                    st_down = 1'b0;
                end
                CHK_EDGE: begin
                    if (cf_release) begin
                        r.code = EV_RELEASED;
                        r.dur  = st_held;
                    end
                    st_edge = cf_pressed;
                    st_down = 1'b0;
                end
                default: begin
                    r.code = EV_LONG;
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady)      return 0;
        else if (r < 65) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 60);
    endfunction

    // Write one register while the block is idle; the predictor follows at the write edge.
    task automatic set_reg(input t_cfg_idx idx, input t_cfg_data val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PRESSED_LEVEL: begin
                cf_pressed = val[0];
                clear_debouncer();
            end
            CFG_RELEASE_ENABLE:  cf_release = val[0];
            CFG_LONG_PRESS:      cf_long    = val;
            CFG_SETTLE_ACTIVE:   cf_act     = val;
            CFG_SETTLE_INACTIVE: cf_inact   = val;
            default: ;
        endcase
    endtask

    // Wait until every queued request is taken and every result has come back,
    // then give the single output stage time to go quiet.
    task automatic wait_drained();
        while (pin_queue.size() != 0 || req_ch.valid || tick_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic push_run(input logic lvl, input int unsigned cnt);
        repeat (cnt) pin_queue.push_back(lvl);
    endtask

    task automatic push_noise(input int unsigned cnt);
        repeat (cnt) pin_queue.push_back(1'($urandom_range(0, 1)));
    endtask

    // Queue about n ticks: mostly full presses with bouncy edges, some short presses
    // that may not settle, and some plain noise.
    task automatic queue_presses(input int unsigned n);
        int unsigned start;
        int unsigned kind;
        int unsigned len;
        int unsigned hold_max;
        start = pin_queue.size();
        while (pin_queue.size() - start < n) begin
            kind     = $urandom_range(0, 99);
            hold_max = cf_act + 3 + ((cf_long <= 8) ? 2 * cf_long : 4);
            if (kind < 15) begin
                push_noise($urandom_range(1, 6));
            end else begin
                push_noise($urandom_range(0, 2));
                if (kind < 30)
                    len = $urandom_range(1, cf_act + 1);
                else
                    len = $urandom_range(1, hold_max);
                push_run(cf_pressed, len);
                push_noise($urandom_range(0, 2));
                push_run(~cf_pressed, $urandom_range(1, cf_inact + 4));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: hold a request until taken, then pause at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else if (!(req_ch.valid && !req_ch.ready)) begin
            if (send_gap != 0) begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pin_queue.size() != 0) begin
                req_ch.valid     <= 1'b1;
                req_ch.pin_level <= pin_queue.pop_front();
                send_gap         <= pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus one long hold-off on request,
    // so the output register fills and the block drops its input ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= 0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_OFF_CYCLES;
        end else if (sink_stall != 0) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= sink_stall - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 45)
                sink_stall <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, then
    // predict the result of any request taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_tick_result want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (tick_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result: event %0d duration %0d",
                                 $realtime, res_ch.event_code, res_ch.press_duration);
                end else begin
                    want = tick_results.pop_front();
                    if (want.code !== res_ch.event_code
                            || want.dur !== res_ch.press_duration) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] result differs: expected event %0d ",
                                      "duration %0d, got event %0d duration %0d"},
                                     $realtime, want.code, want.dur,
                                     res_ch.event_code, res_ch.press_duration);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                tick_results.push_back(advance_debouncer(req_ch.pin_level));
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned phase;
        int unsigned pick;
        int i;

        // Known levels on every input from time zero.
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_PRESSED_LEVEL;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.pin_level = 1'b0;
        res_ch.ready     = 1'b0;
        mismatches       = 0;
        steady           = 1'b0;
        hold_off_req     = 1'b0;

        cf_pressed = RST_PRESSED_LEVEL;
        cf_release = RST_RELEASE_ENABLE;
        cf_long    = RST_LONG_PRESS;
        cf_act     = RST_SETTLE_ACTIVE;
        cf_inact   = RST_SETTLE_INACTIVE;
        clear_debouncer();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under reset settings.
        for (i = 21; i >= 0; i--)
            pin_queue.push_back(DIRECTED_PINS[i]);
        wait_drained();

        // Active-high button, release events suppressed (bits above bit 0 set
        // to prove they are ignored), fast long press.
        set_reg(CFG_PRESSED_LEVEL, 8'hFF);
        set_reg(CFG_RELEASE_ENABLE, 8'hFE);
        set_reg(CFG_LONG_PRESS, 8'd2);
        set_reg(CFG_SETTLE_ACTIVE, 8'd1);
        set_reg(CFG_SETTLE_INACTIVE, 8'd2);
        queue_presses(50);
        wait_drained();

        // Zero settle limits and a long press on every held tick; a write to
        // an unmapped index must change nothing. Hold the receiver off here.
        set_reg(CFG_PRESSED_LEVEL, 8'h02);
        set_reg(CFG_RELEASE_ENABLE, 8'h01);
        set_reg(CFG_LONG_PRESS, 8'd1);
        set_reg(CFG_SETTLE_ACTIVE, 8'd0);
        set_reg(CFG_SETTLE_INACTIVE, 8'd0);
        set_reg(CFG_UNMAPPED, 8'hFF);
        queue_presses(50);
        hold_off_req = 1'b1;
        wait_drained();

        // Largest settle limits with long press off: one press held long enough
        // for the hold counter and the long-press counter to wrap.
        steady = 1'b1;
        set_reg(CFG_PRESSED_LEVEL, 8'h01);
        set_reg(CFG_LONG_PRESS, 8'd0);
        set_reg(CFG_SETTLE_ACTIVE, 8'd255);
        set_reg(CFG_SETTLE_INACTIVE, 8'd255);
        push_run(1'b1, 300);
        push_run(1'b0, 6);
        wait_drained();

        // Random settings, small limits so presses stay short.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady = (phase % 3 == 1);
            pick   = $urandom_range(0, 9);
            set_reg(CFG_PRESSED_LEVEL, t_cfg_data'($urandom_range(0, 255)));
            set_reg(CFG_RELEASE_ENABLE, t_cfg_data'($urandom_range(0, 255)));
            if (phase == 0 || pick == 0)
                set_reg(CFG_LONG_PRESS, 8'd255);
            else if (pick < 4)
                set_reg(CFG_LONG_PRESS, 8'd0);
            else
                set_reg(CFG_LONG_PRESS, t_cfg_data'($urandom_range(1, 6)));
            set_reg(CFG_SETTLE_ACTIVE, t_cfg_data'($urandom_range(0, 4)));
            set_reg(CFG_SETTLE_INACTIVE, t_cfg_data'($urandom_range(0, 4)));
            queue_presses(PHASE_ITEMS);
            wait_drained();
        end

        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && tick_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bdlp_pkg.sv
hdl/bdlp_req_if.sv
hdl/bdlp_res_if.sv
hdl/button_debounce_long_press_unit.sv
bench/tb_button_debounce_long_press_unit.sv
